### rtl/brrc_pkg.sv
package brrc_pkg;

    // Sizing of the admission engine
    localparam int PROCESSES = 8;
    localparam int RESOURCES = 4;
    localparam int UNIT_BITS = 8;

    // Transaction field widths
    localparam int FUNC_W   = 3;
    localparam int PROC_W   = 3;
    localparam int RES_W    = 2;
    localparam int AMT_W    = 8;
    localparam int STATUS_W = 3;

    // Derived widths
    localparam int CELLS  = PROCESSES * RESOURCES;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RIDX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int NEED_W = UNIT_BITS + 1;
    localparam int WORK_W = UNIT_BITS + $clog2(PROCESSES + 1);
    localparam int AN_W   = UNIT_BITS + NEED_W;

    typedef logic [UNIT_BITS-1:0]        t_unit;
    typedef logic signed [NEED_W-1:0]    t_need;
    typedef logic [WORK_W-1:0]           t_work;
    typedef logic [CELL_W-1:0]           t_cell;
    typedef logic [RIDX_W-1:0]           t_ridx;
    typedef logic [PIDX_W-1:0]           t_pidx;
    typedef logic [STATUS_W-1:0]         t_status;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_AVAIL = 3'd0;
    localparam logic [FUNC_W-1:0] FN_MAX   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REQ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

    // Result status codes
    localparam t_status ST_GRANTED = 3'd0;
    localparam t_status ST_REFUSED = 3'd1;
    localparam t_status ST_ROLLED  = 3'd2;
    localparam t_status ST_SAFE    = 3'd3;
    localparam t_status ST_UNSAFE  = 3'd4;

    // Table address of one process and resource
    function automatic t_cell cell_idx(input t_pidx p, input t_ridx r);
        int idx;
        idx = int'(p) * RESOURCES + int'(r);
        return CELL_W'(idx);
    endfunction

    // Keep an amount field to the unit width
    function automatic t_unit to_unit(input logic [AMT_W-1:0] amount);
        logic [AMT_W+UNIT_BITS-1:0] ext;
        ext = {{UNIT_BITS{1'b0}}, amount};
        return ext[UNIT_BITS-1:0];
    endfunction

endpackage

### rtl/banker_resource_request_check.sv
// Banker's algorithm admission engine. One transaction is taken at a time
// (o_in_stall is high while one is at work). Available-unit, max-need and
// request-element loads are taken without leaving S_IDLE; an allocation
// load passes through S_ALLOC, since its need entry is computed from the
// stored maximum. A deciding request element reads the process row through
// the registered read (S_CHK), writes the tentative row back (S_APPLY), then
// runs the safety check; a refused request ends after the row read. The safety
// check streams the allocation/need table through its single read port at
// one cell per cycle, so one pass covers PROCESSES*RESOURCES cells and a
// check runs up to PROCESSES passes. An unsafe request then restores the row
// (S_RB). Each result waits in S_RES until the output register is free, which
// then holds it under o_out_valid while the block already accepts the next
// transaction. All tables read as zero after reset.
module banker_resource_request_check
    import brrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [PROC_W-1:0]   i_process,
    input  logic [RES_W-1:0]    i_resource,
    input  logic [AMT_W-1:0]    i_amount,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_granted
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_RB    = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    localparam t_ridx R_LAST = RIDX_W'(RESOURCES - 1);
    localparam t_pidx P_LAST = PIDX_W'(PROCESSES - 1);

    // Table memories: max need, and {allocation, need} per cell
    t_unit              mem_max [CELLS];
    logic [AN_W-1:0]    mem_an  [CELLS];
    logic [CELLS-1:0]   r_max_vld, n_max_vld;
    logic [CELLS-1:0]   r_an_vld, n_an_vld;
    t_unit              r_max_q;
    logic               r_max_qv;
    logic [AN_W-1:0]    r_an_q;
    logic               r_an_qv;

    // Memory port controls
    logic               max_we;
    t_cell              max_wa;
    t_unit              max_wd;
    t_cell              max_ra;
    logic               an_we;
    t_cell              an_wa;
    logic [AN_W-1:0]    an_wd;
    logic               an_re;
    t_cell              an_ra;
    t_ridx              iss_res;
    t_pidx              iss_proc;

    // Control and working registers
    logic [2:0]         r_state, n_state;
    t_pidx              r_proc, n_proc;
    t_ridx              r_res, n_res;
    t_unit              r_amt, n_amt;
    logic               r_is_req, n_is_req;
    t_ridx              r_cnt, n_cnt;
    logic               r_iss_end, n_iss_end;
    logic               r_bad, n_bad;
    t_pidx              r_sp, n_sp;
    t_ridx              r_sr, n_sr;
    logic               r_fit, n_fit;
    logic               r_prog, n_prog;
    logic               r_dv;
    t_pidx              r_dproc;
    t_ridx              r_dres;
    t_unit              r_avail [RESOURCES];
    t_unit              n_avail [RESOURCES];
    t_unit              r_req [RESOURCES];
    t_unit              n_req [RESOURCES];
    t_work              r_work [RESOURCES];
    t_work              n_work [RESOURCES];
    t_unit              r_row_alloc [RESOURCES];
    t_unit              n_row_alloc [RESOURCES];
    t_need              r_row_need [RESOURCES];
    t_need              n_row_need [RESOURCES];
    t_unit              r_sc_alloc [RESOURCES];
    t_unit              n_sc_alloc [RESOURCES];
    logic [PROCESSES-1:0] r_fin, n_fin;
    t_status            r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic               r_out_granted, n_out_granted;

    // Decoded input and memory data
    logic               in_acc;
    logic               res_ok;
    logic               p_ok;
    t_ridx              in_ri;
    t_pidx              in_pi;
    t_unit              in_unit;
    t_unit              max_val;
    logic [AN_W-1:0]    an_val;
    t_unit              d_alloc;
    t_need              d_need;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign res_ok      = (int'(i_resource) < RESOURCES);
    assign p_ok        = (int'(i_process) < PROCESSES);
    assign in_ri       = RIDX_W'(i_resource);
    assign in_pi       = PIDX_W'(i_process);
    assign in_unit     = to_unit(i_amount);
    assign max_val     = r_max_qv ? r_max_q : '0;
    assign an_val      = r_an_qv ? r_an_q : '0;
    assign d_alloc     = an_val[AN_W-1:NEED_W];
    assign d_need      = t_need'(an_val[NEED_W-1:0]);
    assign max_ra      = cell_idx(in_pi, in_ri);

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_granted   = r_out_granted;

    // Next-state and datapath logic
    always_comb begin
        logic start_scan;
        logic over_need;
        logic over_avail;
        logic bad_now;
        logic fit_now;
        logic take;
        logic prog_now;
        logic [UNIT_BITS+1:0] req_x;
        logic [UNIT_BITS+1:0] need_x;
        logic [WORK_W:0]      need_w;
        logic [WORK_W:0]      work_w;
        t_unit                add;
        t_unit                cur_req;

        start_scan    = 1'b0;
        over_need     = 1'b0;
        over_avail    = 1'b0;
        bad_now       = r_bad;
        fit_now       = r_fit;
        take          = 1'b0;
        prog_now      = r_prog;
        req_x         = '0;
        need_x        = '0;
        need_w        = '0;
        work_w        = '0;
        add           = '0;
        cur_req       = r_req[r_cnt];

        n_state       = r_state;
        n_proc        = r_proc;
        n_res         = r_res;
        n_amt         = r_amt;
        n_is_req      = r_is_req;
        n_cnt         = r_cnt;
        n_iss_end     = r_iss_end;
        n_bad         = r_bad;
        n_sp          = r_sp;
        n_sr          = r_sr;
        n_fit         = r_fit;
        n_prog        = r_prog;
        n_avail       = r_avail;
        n_req         = r_req;
        n_work        = r_work;
        n_row_alloc   = r_row_alloc;
        n_row_need    = r_row_need;
        n_sc_alloc    = r_sc_alloc;
        n_fin         = r_fin;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_max_vld     = r_max_vld;
        n_an_vld      = r_an_vld;

        max_we   = 1'b0;
        max_wa   = cell_idx(in_pi, in_ri);
        max_wd   = in_unit;
        an_we    = 1'b0;
        an_wa    = cell_idx(r_proc, r_cnt);
        an_wd    = '0;
        an_re    = 1'b0;
        an_ra    = cell_idx(r_proc, r_cnt);
        iss_res  = r_cnt;
        iss_proc = r_proc;

        // Drop the output transaction once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_func)
                        FN_AVAIL: begin
                            if (res_ok) begin
                                n_avail[in_ri] = in_unit;
                            end
                        end
                        FN_MAX: begin
                            if (res_ok && p_ok) begin
                                max_we = 1'b1;
                                n_max_vld[max_wa] = 1'b1;
                            end
                        end
                        FN_ALLOC: begin
                            if (res_ok && p_ok) begin
                                n_proc  = in_pi;
                                n_res   = in_ri;
                                n_amt   = in_unit;
                                n_state = S_ALLOC;
                            end
                        end
                        FN_REQ: begin
                            if (res_ok) begin
                                n_req[in_ri] = in_unit;
                            end
                            if (i_last) begin
                                n_is_req = 1'b1;
                                n_proc   = in_pi;
                                if (!p_ok) begin
                                    n_res_status = ST_REFUSED;
                                    n_state      = S_RES;
                                end else begin
                                    n_cnt     = '0;
                                    n_iss_end = 1'b0;
                                    n_bad     = 1'b0;
                                    n_state   = S_CHK;
                                end
                            end
                        end
                        FN_QUERY: begin
                            n_is_req   = 1'b0;
                            start_scan = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Write allocation and need from the stored maximum
            S_ALLOC: begin
                an_we = 1'b1;
                an_wa = cell_idx(r_proc, r_res);
                an_wd = {r_amt, t_need'($signed({1'b0, max_val}) - $signed({1'b0, r_amt}))};
                n_an_vld[an_wa] = 1'b1;
                n_state = S_IDLE;
            end

            // Read the process row and test the request against it
            S_CHK: begin
                if (!r_iss_end) begin
                    an_re   = 1'b1;
                    an_ra   = cell_idx(r_proc, r_cnt);
                    iss_res = r_cnt;
                    if (r_cnt == R_LAST) begin
                        n_iss_end = 1'b1;
                        n_cnt     = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (r_dv) begin
                    n_row_alloc[r_dres] = d_alloc;
                    n_row_need[r_dres]  = d_need;
                    req_x      = {2'b00, r_req[r_dres]};
                    need_x     = {d_need[NEED_W-1], d_need};
                    over_need  = $signed(req_x) > $signed(need_x);
                    over_avail = r_req[r_dres] > r_avail[r_dres];
                    bad_now    = r_bad || over_need || over_avail;
                    n_bad      = bad_now;
                    if (r_dres == R_LAST) begin
                        if (bad_now) begin
                            n_res_status = ST_REFUSED;
                            n_state      = S_RES;
                        end else begin
                            for (int r = 0; r < RESOURCES; r++) begin
                                n_avail[r] = r_avail[r] - r_req[r];
                            end
                            n_cnt   = '0;
                            n_state = S_APPLY;
                        end
                    end
                end
            end

            // Write the tentative row back
            S_APPLY: begin
                an_we = 1'b1;
                an_wa = cell_idx(r_proc, r_cnt);
                an_wd = {r_row_alloc[r_cnt] + cur_req,
                         t_need'(r_row_need[r_cnt] - $signed({1'b0, cur_req}))};
                n_an_vld[an_wa] = 1'b1;
                if (r_cnt == R_LAST) begin
                    n_cnt      = '0;
                    start_scan = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Stream the table, one cell per cycle, pass after pass
            S_SCAN: begin
                an_re    = 1'b1;
                an_ra    = cell_idx(r_sp, r_sr);
                iss_res  = r_sr;
                iss_proc = r_sp;
                if (r_sr == R_LAST) begin
                    n_sr = '0;
                    n_sp = (r_sp == P_LAST) ? '0 : r_sp + 1'b1;
                end else begin
                    n_sr = r_sr + 1'b1;
                end
                if (r_dv) begin
                    need_w  = {{(WORK_W + 1 - NEED_W){d_need[NEED_W-1]}}, d_need};
                    work_w  = {1'b0, r_work[r_dres]};
                    fit_now = r_fit && ($signed(need_w) <= $signed(work_w));
                    n_sc_alloc[r_dres] = d_alloc;
                    if (r_dres != R_LAST) begin
                        n_fit = fit_now;
                    end else begin
                        n_fit = 1'b1;
                        take  = fit_now && !r_fin[r_dproc];
                        if (take) begin
                            for (int r = 0; r < RESOURCES; r++) begin
                                add = (r == RESOURCES - 1) ? d_alloc : r_sc_alloc[r];
                                n_work[r] = r_work[r] + WORK_W'(add);
                            end
                            n_fin[r_dproc] = 1'b1;
                        end
                        prog_now = r_prog || take;
                        n_prog   = prog_now;
                        // Close the pass after the last process
                        if (r_dproc == P_LAST) begin
                            n_prog = 1'b0;
                            if (&n_fin) begin
                                n_res_status = r_is_req ? ST_GRANTED : ST_SAFE;
                                n_state      = S_RES;
                            end else if (!prog_now) begin
                                if (r_is_req) begin
                                    for (int r = 0; r < RESOURCES; r++) begin
                                        n_avail[r] = r_avail[r] + r_req[r];
                                    end
                                    n_cnt   = '0;
                                    n_state = S_RB;
                                end else begin
                                    n_res_status = ST_UNSAFE;
                                    n_state      = S_RES;
                                end
                            end
                        end
                    end
                end
            end

            // Restore the original row
            S_RB: begin
                an_we = 1'b1;
                an_wa = cell_idx(r_proc, r_cnt);
                an_wd = {r_row_alloc[r_cnt], r_row_need[r_cnt]};
                n_an_vld[an_wa] = 1'b1;
                if (r_cnt == R_LAST) begin
                    n_cnt        = '0;
                    n_res_status = ST_ROLLED;
                    n_state      = S_RES;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Hand the result to the output register when it is free
            S_RES: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = (r_res_status == ST_GRANTED) ||
                                    (r_res_status == ST_SAFE);
                    if (r_is_req) begin
                        for (int r = 0; r < RESOURCES; r++) begin
                            n_req[r] = '0;
                        end
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the work vector and clear the finish flags
        if (start_scan) begin
            for (int r = 0; r < RESOURCES; r++) begin
                n_work[r] = WORK_W'(r_avail[r]);
            end
            n_fin   = '0;
            n_sp    = '0;
            n_sr    = '0;
            n_fit   = 1'b1;
            n_prog  = 1'b0;
            n_state = S_SCAN;
        end
    end

    // Table memories with registered read
    always_ff @(posedge i_clk) begin
        if (max_we) begin
            mem_max[max_wa] <= max_wd;
        end
        r_max_q <= mem_max[max_ra];
        if (an_we) begin
            mem_an[an_wa] <= an_wd;
        end
        r_an_q <= mem_an[an_ra];
    end

    // Control state and architectural vectors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_vld   <= '0;
            r_an_vld    <= '0;
            r_max_qv    <= 1'b0;
            r_an_qv     <= 1'b0;
            r_dv        <= 1'b0;
            r_fin       <= '0;
            r_is_req    <= 1'b0;
            for (int r = 0; r < RESOURCES; r++) begin
                r_avail[r] <= '0;
                r_req[r]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_max_vld   <= n_max_vld;
            r_an_vld    <= n_an_vld;
            r_max_qv    <= r_max_vld[max_ra];
            r_an_qv     <= r_an_vld[an_ra];
            r_dv        <= an_re;
            r_fin       <= n_fin;
            r_is_req    <= n_is_req;
            r_avail     <= n_avail;
            r_req       <= n_req;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_proc        <= n_proc;
        r_res         <= n_res;
        r_amt         <= n_amt;
        r_cnt         <= n_cnt;
        r_iss_end     <= n_iss_end;
        r_bad         <= n_bad;
        r_sp          <= n_sp;
        r_sr          <= n_sr;
        r_fit         <= n_fit;
        r_prog        <= n_prog;
        r_dproc       <= iss_proc;
        r_dres        <= iss_res;
        r_work        <= n_work;
        r_row_alloc   <= n_row_alloc;
        r_row_need    <= n_row_need;
        r_sc_alloc    <= n_sc_alloc;
        r_res_status  <= n_res_status;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
    end

endmodule

### tb/banker_resource_request_check_chk.sv
module banker_resource_request_check_chk
    import brrc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [PROC_W-1:0]   i_process,
    input  wire logic [RES_W-1:0]    i_resource,
    input  wire logic [AMT_W-1:0]    i_amount,
    input  wire logic                i_last,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic                i_granted,
    output int                       o_fail_count,
    output int                       o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status status;
        logic    granted;
    } t_verdict;

    // Shadow of the admission engine tables
    t_unit    free_units [RESOURCES];
    t_unit    max_tbl    [CELLS];
    t_unit    alloc_tbl  [CELLS];
    t_need    need_tbl   [CELLS];
    t_unit    req_buf    [RESOURCES];

    t_verdict verdicts_due [$];
    int       fail_count;
    int       waiting;

    assign o_fail_count = fail_count;
    assign o_waiting    = waiting;

    initial begin
        fail_count = 0;
        waiting    = 0;
    end

    function automatic void clear_ledger();
        for (int r = 0; r < RESOURCES; r++) begin
            free_units[r] = '0;
            req_buf[r]    = '0;
        end
        for (int c = 0; c < CELLS; c++) begin
            max_tbl[c]   = '0;
            alloc_tbl[c] = '0;
            need_tbl[c]  = '0;
        end
    endfunction

    // Run passes until every process finishes or a pass finishes none
    function automatic bit ledger_is_safe();
        t_work work [RESOURCES];
        bit    done [PROCESSES];
        int    finished;
        bit    progress;
        bit    fits;
        for (int r = 0; r < RESOURCES; r++)
            work[r] = t_work'(free_units[r]);
        for (int p = 0; p < PROCESSES; p++)
            done[p] = 1'b0;
        finished = 0;
        while (finished < PROCESSES) begin
            progress = 1'b0;
            for (int p = 0; p < PROCESSES; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < RESOURCES; r++)
                        if (int'(need_tbl[p*RESOURCES+r]) > int'(work[r]))
                            fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < RESOURCES; r++)
                            work[r] = work[r] + t_work'(alloc_tbl[p*RESOURCES+r]);
                        done[p]  = 1'b1;
                        finished++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Refuse, grant, or apply tentatively and roll back when unsafe
    function automatic t_status judge_request(input int p);
        int c;
        if (p >= PROCESSES)
            return ST_REFUSED;
        for (int r = 0; r < RESOURCES; r++) begin
            c = p * RESOURCES + r;
            if (int'(req_buf[r]) > int'(need_tbl[c]) || req_buf[r] > free_units[r])
                return ST_REFUSED;
        end
        for (int r = 0; r < RESOURCES; r++) begin
            c = p * RESOURCES + r;
            free_units[r] = free_units[r] - req_buf[r];
            alloc_tbl[c]  = alloc_tbl[c] + req_buf[r];
            need_tbl[c]   = need_tbl[c] - t_need'({1'b0, req_buf[r]});
        end
        if (ledger_is_safe())
            return ST_GRANTED;
        for (int r = 0; r < RESOURCES; r++) begin
            c = p * RESOURCES + r;
            free_units[r] = free_units[r] + req_buf[r];
            alloc_tbl[c]  = alloc_tbl[c] - req_buf[r];
            need_tbl[c]   = need_tbl[c] + t_need'({1'b0, req_buf[r]});
        end
        return ST_ROLLED;
    endfunction

    // Update the shadow tables for one accepted transaction
    function automatic void apply_txn(input logic [FUNC_W-1:0] f, input int p, input int r,
                                      input t_unit amt, input logic lst);
        int       c;
        bit       safe;
        t_verdict due;
        c = p * RESOURCES + r;
        case (f)
            FN_AVAIL: begin
                if (r < RESOURCES)
                    free_units[r] = amt;
            end
            FN_MAX: begin
                if (r < RESOURCES && p < PROCESSES)
                    max_tbl[c] = amt;
            end
            FN_ALLOC: begin
                if (r < RESOURCES && p < PROCESSES) begin
                    alloc_tbl[c] = amt;
                    need_tbl[c]  = t_need'({1'b0, max_tbl[c]}) - t_need'({1'b0, amt});
                end
            end
            FN_REQ: begin
                if (r < RESOURCES)
                    req_buf[r] = amt;
                if (lst) begin
                    due.status  = judge_request(p);
                    due.granted = (due.status == ST_GRANTED);
                    verdicts_due.insert(verdicts_due.size(), due);
                    for (int k = 0; k < RESOURCES; k++)
                        req_buf[k] = '0;
                end
            end
            FN_QUERY: begin
                safe        = ledger_is_safe();
                due.status  = safe ? ST_SAFE : ST_UNSAFE;
                due.granted = safe;
                verdicts_due.insert(verdicts_due.size(), due);
            end
            default: ;
        endcase
    endfunction

    // Retire results before absorbing the transaction taken at the same edge
    always @(posedge i_clk) begin : track
        t_verdict due;
        if (!i_rst_n) begin
            clear_ledger();
            verdicts_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $error("result with none expected: status %0d granted %0d",
                           i_status, i_granted);
                    fail_count++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_status !== due.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               due.status, i_status);
                        fail_count++;
                    end
                    if (i_granted !== due.granted) begin
                        $error("granted mismatch: expected %0d, actual %0d",
                               due.granted, i_granted);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_txn(i_func, int'(i_process), int'(i_resource), t_unit'(i_amount),
                          i_last);
        end
        waiting = verdicts_due.size();
    end

endmodule

### tb/banker_resource_request_check_tb.sv
module banker_resource_request_check_tb
    import brrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Func codes the block ignores
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

    localparam int ITEM_TARGET    = 1550;
    localparam int MAX_WAIT       = 19;
    localparam int LONG_HOLD_AT   = 40;
    localparam int LONG_HOLD_LEN  = 800;
    localparam int DRAIN_CYCLES   = 400;
    localparam int CYCLE_LIMIT    = 3_000_000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [PROC_W-1:0]   proc_id;
    logic [RES_W-1:0]    res_id;
    logic [AMT_W-1:0]    amount;
    logic                last;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] out_status;
    logic                out_granted;

    int fail_count;
    int waiting;
    int items_sent  = 0;
    int cycle_count = 0;
    bit snd_no_wait = 1'b0;

    banker_resource_request_check u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_func      (func),
        .i_process   (proc_id),
        .i_resource  (res_id),
        .i_amount    (amount),
        .i_last      (last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (out_status),
        .o_granted   (out_granted)
    );

    banker_resource_request_check_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_func       (func),
        .i_process    (proc_id),
        .i_resource   (res_id),
        .i_amount     (amount),
        .i_last       (last),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (out_status),
        .i_granted    (out_granted),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Draw a stall per result; hold off once for a long stretch to back the block up
    initial begin : receiver
        int hold;
        int taken;
        bit no_wait;
        hold    = 0;
        taken   = 0;
        no_wait = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                taken++;
                if (taken == LONG_HOLD_AT)
                    hold = LONG_HOLD_LEN;
                else
                    hold = no_wait ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 15) == 0)
                    no_wait = !no_wait;
            end
        end
    end

    // Offer one transaction after a random gap and hold it until taken
    task automatic send_txn(input logic [FUNC_W-1:0] f, input int p, input int r,
                            input int amt, input logic lst);
        int gap;
        gap = snd_no_wait ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 15) == 0)
            snd_no_wait = !snd_no_wait;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        proc_id  <= PROC_W'(p);
        res_id   <= RES_W'(r);
        amount   <= AMT_W'(amt);
        last     <= lst;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    function automatic logic coin();
        return logic'($urandom_range(0, 1));
    endfunction

    // Anything at all, ignored funcs and stray request elements included
    task automatic send_noise();
        send_txn(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, PROCESSES - 1),
                 $urandom_range(0, RESOURCES - 1), $urandom_range(0, 255), coin());
    endtask

    // Load free units and table entries, then issue requests and queries
    task automatic run_scenario();
        bit wide;
        bit full;
        int unit_top;
        int req_top;
        int cells;
        int reqs;
        int elems;
        int p;
        int r;
        int mx;
        int al;
        wide     = ($urandom_range(0, 5) == 0);
        unit_top = wide ? 255 : 12;
        req_top  = wide ? 60 : 4;
        for (int k = 0; k < RESOURCES; k++)
            send_txn(FN_AVAIL, $urandom_range(0, PROCESSES - 1), k,
                     $urandom_range(0, unit_top), coin());
        full  = ($urandom_range(0, 3) == 0);
        cells = full ? CELLS : $urandom_range(2, 12);
        for (int i = 0; i < cells; i++) begin
            p  = full ? i / RESOURCES : $urandom_range(0, PROCESSES - 1);
            r  = full ? i % RESOURCES : $urandom_range(0, RESOURCES - 1);
            mx = $urandom_range(0, unit_top);
            // mostly within the maximum, now and then past it for a negative need
            al = ($urandom_range(0, 9) == 0) ? $urandom_range(0, unit_top)
                                              : $urandom_range(0, mx);
            send_txn(FN_MAX, p, r, mx, coin());
            send_txn(FN_ALLOC, p, r, al, coin());
        end
        send_txn(FN_QUERY, $urandom_range(0, PROCESSES - 1),
                 $urandom_range(0, RESOURCES - 1), $urandom_range(0, 255), coin());
        reqs = $urandom_range(2, 10);
        for (int q = 0; q < reqs; q++) begin
            p     = $urandom_range(0, PROCESSES - 1);
            elems = $urandom_range(1, RESOURCES);
            for (int e = 0; e < elems; e++)
                send_txn(FN_REQ, p, $urandom_range(0, RESOURCES - 1),
                         $urandom_range(0, req_top), logic'(e == elems - 1));
            if ($urandom_range(0, 5) == 0)
                send_txn(FN_QUERY, $urandom_range(0, PROCESSES - 1),
                         $urandom_range(0, RESOURCES - 1), $urandom_range(0, 255), coin());
            if ($urandom_range(0, 11) == 0)
                send_noise();
        end
    endtask

    initial begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = '0;
        proc_id  = '0;
        res_id   = '0;
        amount   = '0;
        last     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty state is safe
        send_txn(FN_QUERY, 0, 0, 0, 1'b0);
        // Extremes of free units, need at its top and below zero
        send_txn(FN_AVAIL, 0, 0, 255, 1'b0);
        send_txn(FN_AVAIL, 0, 3, 128, 1'b1);
        send_txn(FN_MAX, 7, 3, 255, 1'b0);
        send_txn(FN_ALLOC, 7, 3, 0, 1'b0);
        send_txn(FN_MAX, 0, 0, 5, 1'b0);
        send_txn(FN_ALLOC, 0, 0, 200, 1'b0);
        send_txn(FN_QUERY, 0, 0, 0, 1'b0);
        // Refused: above a negative need, then above the free units
        send_txn(FN_REQ, 0, 0, 1, 1'b1);
        send_txn(FN_REQ, 7, 3, 200, 1'b1);
        send_txn(FN_AVAIL, 0, 3, 255, 1'b0);
        send_txn(FN_QUERY, 0, 0, 0, 1'b0);
        // Two-element request, unwritten elements count as zero
        send_txn(FN_REQ, 7, 2, 0, 1'b0);
        send_txn(FN_REQ, 7, 3, 100, 1'b1);
        // Strand one process so that any applied request is rolled back
        send_txn(FN_MAX, 2, 1, 1, 1'b0);
        send_txn(FN_ALLOC, 2, 1, 0, 1'b0);
        send_txn(FN_REQ, 7, 3, 0, 1'b1);
        send_txn(FN_SPARE_A, 7, 3, 255, 1'b1);
        send_txn(FN_SPARE_B, 5, 2, 170, 1'b0);
        send_txn(FN_SPARE_C, 2, 1, 85, 1'b1);
        send_txn(FN_QUERY, 5, 1, 255, 1'b1);
        // Release the stranded process, then an all-zero request
        send_txn(FN_ALLOC, 2, 1, 1, 1'b0);
        send_txn(FN_REQ, 5, 1, 0, 1'b1);
        send_txn(FN_QUERY, 2, 2, 0, 1'b0);

        // Random well-formed scenarios with some noise
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                run_scenario();
        end

        // Drain and give the verdict
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
